>>> hdl/frame_interval_averager_defines.svh
// ----------------------------------------------------------------------------
// Frame interval averager assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_AVERAGER_DEFINES_SVH
`define FRAME_INTERVAL_AVERAGER_DEFINES_SVH

// check a condition on every clock outside reset
`define FIA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("frame_interval_averager: assertion failed");

// check that a trigger is followed by a condition on the next clock
`define FIA_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("frame_interval_averager: assertion failed");

`endif

>>> hdl/fia_pkg.sv
// ----------------------------------------------------------------------------
// Frame interval averager package
// Field widths, constants, action codes and sequencer states.
// ----------------------------------------------------------------------------
package fia_pkg;

  localparam int STAMP_W = 48;
  localparam int IVL_W   = 32;
  localparam int RATE_W  = 16;
  localparam int WIN_W   = 33;

  localparam logic [IVL_W-1:0]  TPS_RESET = 32'd10000000;
  localparam logic [IVL_W-1:0]  IVL_MAX   = '1;
  localparam logic [RATE_W-1:0] RATE_MAX  = '1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IVL,
    ST_GAME,
    ST_DIFF,
    ST_TEST,
    ST_PUSH,
    ST_EVICT,
    ST_WIN,
    ST_CLOSE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } fia_state_t;

endpackage

>>> hdl/fia_history.sv
// ----------------------------------------------------------------------------
// Frame interval history memory
// Single-port-write, registered-read store of accepted frame intervals.
// ----------------------------------------------------------------------------
module fia_history #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> hdl/fia_divider.sv
// ----------------------------------------------------------------------------
// Frame interval averager divider
// Restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module fia_divider #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 7,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem, quo[NUM_W-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[Q_W-1:0];

endmodule

>>> hdl/frame_interval_averager.sv
// ----------------------------------------------------------------------------
// Frame interval averager
// Frame-time moving average and frames-per-second counter on tick stamps.
// ----------------------------------------------------------------------------
// Each word carries an action and a 48-bit tick stamp and yields one result
// word: mean accepted frame interval, the latched frame rate of the last full
// second, and ticks since the last start. A start word goes straight to the
// done state. A frame word steps through the interval, game time, difference,
// test, push, evict, window, close and divider states, skipping push and evict
// when its interval does not enter the history and the divide when the
// history is empty; the restoring divider forms the mean, one quotient bit per
// cycle. The block holds in_stall high while a word is in work and takes the
// next word while a finished result still waits on the output. The running
// sum over the history is kept, so the history memory is read once per frame
// word and written once per accepted interval.
module frame_interval_averager #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [fia_pkg::STAMP_W-1:0] timestamp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fia_pkg::IVL_W-1:0]   avg_interval,
  output logic [fia_pkg::RATE_W-1:0]  frame_rate,
  output logic [fia_pkg::STAMP_W-1:0] game_time,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fia_pkg::IVL_W-1:0]   ticks_per_second
);

  import fia_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = IVL_W + CNT_W;

  fia_state_t state, state_next;

  logic [IVL_W-1:0]   tps;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] base_stamp;
  logic [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0] raw;
  logic [STAMP_W-1:0] game;
  logic [IVL_W-1:0]   iv;
  logic [IVL_W-1:0]   diff;
  logic               push_ok;
  logic [CNT_W-1:0]   stored_count;
  logic [AW-1:0]      wptr;
  logic [SUM_W-1:0]   sum;
  logic [RATE_W-1:0]  frames_in_window;
  logic [WIN_W-1:0]   window_ticks;
  logic [RATE_W-1:0]  latched_rate;
  logic [IVL_W-1:0]   mean_interval;

  logic               accept;
  logic               hist_full;
  logic               rd_en;
  logic               wr_en;
  logic [IVL_W-1:0]   evicted;
  logic               div_start;
  logic               div_done;
  logic [IVL_W-1:0]   quotient;
  logic               out_load;

  assign accept    = in_valid && !in_stall;
  assign hist_full = (stored_count == CNT_W'(HISTORY_DEPTH));
  assign raw       = stamp - last_stamp;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (action == ACT_FRAME) ? ST_IVL : ST_DONE;
        end
      end
      ST_IVL:   state_next = ST_GAME;
      ST_GAME:  state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_TEST;
      ST_TEST: begin
        rd_en      = 1'b1;
        state_next = (diff < tps) ? ST_PUSH : ST_WIN;
      end
      ST_PUSH: begin
        wr_en      = 1'b1;
        state_next = ST_EVICT;
      end
      ST_EVICT: state_next = ST_WIN;
      ST_WIN:   state_next = ST_CLOSE;
      ST_CLOSE: state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        if (stored_count == '0) begin
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps              <= TPS_RESET;
      base_stamp       <= '0;
      last_stamp       <= '0;
      stored_count     <= '0;
      wptr             <= '0;
      sum              <= '0;
      frames_in_window <= '0;
      window_ticks     <= '0;
      latched_rate     <= '0;
      mean_interval    <= '0;
      push_ok          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tps <= ticks_per_second;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            stamp <= timestamp;
            if (action == ACT_START) begin
              base_stamp       <= timestamp;
              last_stamp       <= timestamp;
              stored_count     <= '0;
              wptr             <= '0;
              sum              <= '0;
              frames_in_window <= '0;
              window_ticks     <= '0;
              latched_rate     <= '0;
              game             <= '0;
            end
          end
        end
        ST_IVL: begin
          iv         <= (raw[STAMP_W-1:IVL_W] != '0) ? IVL_MAX : raw[IVL_W-1:0];
          last_stamp <= stamp;
        end
        ST_GAME: game <= stamp - base_stamp;
        ST_DIFF: diff <= (iv >= mean_interval) ? iv - mean_interval : mean_interval - iv;
        ST_TEST: push_ok <= (diff < tps);
        ST_PUSH: sum <= sum + SUM_W'(iv);
        ST_EVICT: begin
          if (hist_full) begin
            sum <= sum - SUM_W'(evicted);
          end else begin
            stored_count <= stored_count + CNT_W'(1);
          end
          wptr <= (wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr + AW'(1);
        end
        ST_WIN: begin
          if (frames_in_window != RATE_MAX) begin
            frames_in_window <= frames_in_window + RATE_W'(1);
          end
          window_ticks <= window_ticks + WIN_W'(iv);
        end
        ST_CLOSE: begin
          if (window_ticks > WIN_W'(tps)) begin
            latched_rate     <= frames_in_window;
            frames_in_window <= '0;
            window_ticks     <= '0;
          end
        end
        ST_DIV_GO: begin
          if (stored_count == '0) begin
            mean_interval <= '0;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            mean_interval <= quotient;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_interval <= mean_interval;
      frame_rate   <= latched_rate;
      game_time    <= game;
    end
  end

  fia_history #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW),
    .DW    (IVL_W)
  ) u_history (
    .clk     (clk),
    .wr_en   (wr_en && push_ok),
    .rd_en   (rd_en),
    .addr    (wptr),
    .wr_data (iv),
    .rd_data (evicted)
  );

  fia_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W),
    .Q_W   (IVL_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (stored_count),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

>>> hdl/fia_checker.sv
// ----------------------------------------------------------------------------
// Frame interval averager checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_interval_averager_defines.svh"

module fia_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [fia_pkg::STAMP_W-1:0] game_time,
  input logic                        cfg_ready
);

  import fia_pkg::*;

  `FIA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FIA_ASSERT_NEXT(a_no_result_on_accept, in_valid && !in_stall, !$rose(out_valid))
  `FIA_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(game_time))
  `FIA_ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready)

endmodule

bind frame_interval_averager fia_checker u_fia_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .game_time (game_time),
  .cfg_ready (cfg_ready)
);
